// ===== rtl/isb_pkg.sv =====
`default_nettype none

package isb_pkg;

  // Build depth of the stack and the widths that follow from it
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CAP_RST = 64;

  // Common width for count/capacity compares and output truncation
  localparam int unsigned EXT_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Search priority tree: groups of eight cells
  localparam int unsigned GRP_SZ  = 8;
  localparam int unsigned GRP_IW  = 3;
  localparam int unsigned NGRP    = (DEPTH + GRP_SZ - 1) / GRP_SZ;
  localparam int unsigned NGRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  // Per-cycle control broadcast along the chain
  typedef struct packed {
    logic push;
    logic pop;
    logic search;
  } isb_ctrl_t;

  typedef struct packed {
    logic               status;
    logic [WORD_W-1:0]  data;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } isb_res_t;

endpackage

`default_nettype wire

// ===== rtl/integer_stack_with_search_top.sv =====
// Result path: push, pop, peek and clear results pass through the result register and then the
//   output register; a search first passes match capture, group pick and final pick.
// Throughput: one push, pop, peek or clear item per cycle while the result stages can take it;
//   a search holds the input through the group-pick and final-pick states while the pick settles.
// Reset (rst_ni low, asynchronous): stack empty, capacity 64, no result pending.
//   Stored words are not cleared; only words written since are ever read.
`default_nettype none

module integer_stack_with_search_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: capacity register
  input  wire         cfg_we_i,
  input  wire  [6:0]  cfg_wdata_i,
  // Command items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] value
  input  wire  [2:0]  s_axis_tuser,   // [2:0] cmd
  // Result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] data, [37:32] found_position,
                                      // [44:38] count, [45] is_full, [46] is_empty, [47] zero
  output logic [0:0]  m_axis_tuser    // [0] status
);
  import isb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRP,
    ST_PICK
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   top_count_q, top_count_d;
  logic [CAP_W-1:0]   cap_q;
  logic               res_valid_q, out_valid_q;
  isb_res_t           res_q, out_q, res_d;
  logic               new_res;

  // Chain of cells
  logic [WORD_W-1:0]  word [DEPTH];
  logic [DEPTH-1:0]   match;
  isb_ctrl_t          ctrl;

  logic               out_free, in_acc;
  cmd_e               cmd;
  logic [EXT_W-1:0]   cap_eff, cnt_ext, cnt_after_ext;
  logic               push_ok, nonempty;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   pos_cnt;
  logic [EXT_W-1:0]   pos_ext;

  // ------------------------------------------------------------------
  // Input handshake: take an item only when idle and the result stage
  // will be free at this edge.
  // ------------------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && (!res_valid_q || out_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);

  // Effective capacity saturates at the build depth
  assign cap_eff  = (EXT_W'(cap_q) > EXT_W'(DEPTH)) ? EXT_W'(DEPTH) : EXT_W'(cap_q);
  assign cnt_ext  = EXT_W'(top_count_q);
  assign push_ok  = cnt_ext < cap_eff;
  assign nonempty = top_count_q != '0;

  assign ctrl.push   = in_acc && (cmd == CMD_PUSH) && push_ok;
  assign ctrl.pop    = in_acc && (cmd == CMD_POP) && nonempty;
  assign ctrl.search = in_acc && (cmd == CMD_SEARCH);

  // ------------------------------------------------------------------
  // Cell chain: cell 0 is the top of the stack. Push shifts every word one
  // cell down and loads the new word into cell 0; pop shifts them back up.
  // ------------------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] above, below;
    logic              occupied;

    if (k == 0) begin : g_top
      assign above = s_axis_tdata;
    end else begin : g_mid
      assign above = word[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign below = word[k];
    end else begin : g_inner
      assign below = word[k+1];
    end
    assign occupied = CNT_W'(k) < top_count_q;

    isb_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .above_i    (above),
      .below_i    (below),
      .key_i      (s_axis_tdata),
      .occupied_i (occupied),
      .word_o     (word[k]),
      .match_o    (match[k])
    );
  end

  // Topmost match, as distance from the top of the stack
  isb_prio u_prio (
    .clk_i   (clk_i),
    .match_i (match),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // Position from the bottom: count - 1 - distance from the top
  assign pos_cnt = top_count_q - CNT_W'(1) - CNT_W'(hit_idx);
  assign pos_ext = EXT_W'(pos_cnt[IDX_W-1:0]);

  // ------------------------------------------------------------------
  // Result of the item taken this cycle, or of the finished search
  // ------------------------------------------------------------------
  always_comb begin
    top_count_d = top_count_q;
    res_d       = '0;
    new_res     = 1'b0;
    if (in_acc) begin
      new_res      = (cmd != CMD_SEARCH);
      res_d.status = 1'b1;
      case (cmd)
        CMD_PUSH: begin
          if (push_ok) begin
            top_count_d  = top_count_q + CNT_W'(1);
            res_d.status = 1'b0;
          end
        end
        CMD_POP: begin
          if (nonempty) begin
            top_count_d  = top_count_q - CNT_W'(1);
            res_d.data   = word[0];
            res_d.status = 1'b0;
          end
        end
        CMD_PEEK: begin
          if (nonempty) begin
            res_d.data   = word[0];
            res_d.status = 1'b0;
          end
        end
        CMD_CLEAR: begin
          top_count_d  = '0;
          res_d.status = 1'b0;
        end
        default: begin
          // search finishes later; undefined codes fail with no change
        end
      endcase
    end else if (state_q == ST_PICK) begin
      new_res      = 1'b1;
      res_d.status = !hit;
      res_d.pos    = hit ? pos_ext[POS_W-1:0] : '0;
    end
    cnt_after_ext = EXT_W'(top_count_d);
    res_d.count   = cnt_after_ext[COUNT_W-1:0];
    res_d.full    = cnt_after_ext >= cap_eff;
    res_d.empty   = top_count_d == '0;
  end

  // ------------------------------------------------------------------
  // Sequencer, stack count, capacity and the two result stages
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_count_q <= '0;
      cap_q       <= CAP_W'(CAP_RST);
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      top_count_q <= top_count_d;

      case (state_q)
        ST_IDLE: begin
          if (ctrl.search) begin
            state_q <= ST_GRP;
          end
        end
        ST_GRP:  state_q <= ST_PICK;
        ST_PICK: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase

      // Advance the pending result into the output register
      if (out_free) begin
        out_valid_q <= res_valid_q;
        if (res_valid_q) begin
          out_q <= res_q;
        end
        res_valid_q <= 1'b0;
      end
      // Load a new result (stage is empty or drains at this edge)
      if (new_res) begin
        res_valid_q <= 1'b1;
        res_q       <= res_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.empty, out_q.full, out_q.count, out_q.pos, out_q.data};
  assign m_axis_tuser  = out_q.status;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_count_q <= CNT_W'(DEPTH))
    else $error("stack count beyond depth");

  a_search_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.search |=> (state_q == ST_GRP) ##1 (state_q == ST_PICK) ##1 res_valid_q)
    else $error("search sequence broken");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> top_count_q == $past(top_count_q) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> (EXT_W'(top_count_q) < cap_eff) && (top_count_q < CNT_W'(DEPTH)))
    else $error("push on full stack");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_free) |-> !new_res)
    else $error("result stage overwritten");

endmodule

`default_nettype wire

// ===== rtl/isb_cell.sv =====
`default_nettype none

// One stack entry. Push moves words away from the top, pop moves them back.
module isb_cell (
  input  wire                             clk_i,
  input  wire  isb_pkg::isb_ctrl_t        ctrl_i,
  input  wire  logic [isb_pkg::WORD_W-1:0] above_i,
  input  wire  logic [isb_pkg::WORD_W-1:0] below_i,
  input  wire  logic [isb_pkg::WORD_W-1:0] key_i,
  input  wire                             occupied_i,
  output logic [isb_pkg::WORD_W-1:0]      word_o,
  output logic                            match_o
);
  import isb_pkg::*;

  logic [WORD_W-1:0] word_q;
  logic              match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      word_q <= above_i;
    end else if (ctrl_i.pop) begin
      word_q <= below_i;
    end
    if (ctrl_i.search) begin
      match_q <= occupied_i && (word_q == key_i);
    end
  end

  assign word_o  = word_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== rtl/isb_prio.sv =====
`default_nettype none

// Find the first set match bit (cell nearest the top), two levels:
// registered per-group pick, then a pick across groups.
module isb_prio (
  input  wire                            clk_i,
  input  wire  logic [isb_pkg::DEPTH-1:0] match_i,
  output logic                           hit_o,
  output logic [isb_pkg::IDX_W-1:0]      idx_o
);
  import isb_pkg::*;

  logic [NGRP*GRP_SZ-1:0] match_pad;
  logic [NGRP-1:0]        grp_hit_d, grp_hit_q;
  logic [GRP_IW-1:0]      grp_idx_d [NGRP];
  logic [GRP_IW-1:0]      grp_idx_q [NGRP];
  logic [NGRP_W+GRP_IW-1:0] k_full;
  logic                   hit;

  assign match_pad = {{(NGRP*GRP_SZ-DEPTH){1'b0}}, match_i};

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = GRP_SZ - 1; b >= 0; b--) begin
        if (match_pad[g*GRP_SZ+b]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = GRP_IW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q <= grp_hit_d;
    grp_idx_q <= grp_idx_d;
  end

  always_comb begin
    hit    = 1'b0;
    k_full = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit    = 1'b1;
        k_full = {NGRP_W'(g), grp_idx_q[g]};
      end
    end
  end

  assign hit_o = hit;
  assign idx_o = k_full[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isb_pkg::*;

  // Command codes outside the defined set; the stack must treat them as no-ops
  localparam logic [CMD_W-1:0] CMD_UNDEF5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF7 = 3'd7;

  localparam int unsigned IDLE_PCT       = 35;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;   // search is the slowest command
  localparam int unsigned CYCLE_LIMIT    = 400000;

  localparam logic [WORD_W-1:0] WORD_EXTREMES [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000
  };

  // One row of the directed sequence: either a capacity write or a command item.
  // Where typed is set, the hand-written result is the one checked.
  typedef struct {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic [CMD_W-1:0] cmd;
    logic [WORD_W-1:0] val;
    logic             typed;
    isb_res_t         res;
  } directed_row_t;

  // One phase of the random part
  typedef struct {
    logic [CAP_W-1:0] cap;
    logic             rand_cap;
    int unsigned      push_pct;
    int unsigned      items;
    logic             no_idle;
    logic             rx_hold;
  } phase_t;

  localparam isb_res_t EMPTY_FAIL = '{1'b1, 32'd0, 6'd0, 7'd0, 1'b0, 1'b1};

  directed_row_t directed_rows [29] = '{
    '{1'b0, 7'd0,   CMD_POP,    32'd0,          1'b1, EMPTY_FAIL},
    '{1'b0, 7'd0,   CMD_PEEK,   32'd0,          1'b1, EMPTY_FAIL},
    '{1'b0, 7'd0,   CMD_SEARCH, 32'd0,          1'b1, EMPTY_FAIL},
    '{1'b0, 7'd0,   CMD_PUSH,   32'h7FFF_FFFF,  1'b1, '{1'b0, 32'd0, 6'd0, 7'd1, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   CMD_PUSH,   32'h8000_0000,  1'b1, '{1'b0, 32'd0, 6'd0, 7'd2, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   CMD_PUSH,   32'h0000_0000,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'hFFFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_SEARCH, 32'h7FFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'h7FFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_SEARCH, 32'h7FFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_SEARCH, 32'h1234_5678,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_PEEK,   32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_POP,    32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_UNDEF5, 32'hFFFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_UNDEF6, 32'h0000_0000,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_UNDEF7, 32'hFFFF_FFFF,  1'b0, '0},
    '{1'b0, 7'd0,   CMD_CLEAR,  32'd0,          1'b1, '{1'b0, 32'd0, 6'd0, 7'd0, 1'b0, 1'b1}},
    '{1'b1, 7'd0,   CMD_PUSH,   32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'hAAAA_5555,  1'b1, '{1'b1, 32'd0, 6'd0, 7'd0, 1'b1, 1'b1}},
    '{1'b1, 7'd2,   CMD_PUSH,   32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'd1,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'd2,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'd3,          1'b0, '0},
    '{1'b1, 7'd1,   CMD_PUSH,   32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_SEARCH, 32'd1,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'd4,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_POP,    32'd0,          1'b0, '0},
    '{1'b1, 7'd127, CMD_PUSH,   32'd0,          1'b0, '0},
    '{1'b0, 7'd0,   CMD_PUSH,   32'd5,          1'b0, '0}
  };

  // Phases: fill to the build depth, saturate, shrink below the fill level,
  // zero and tiny capacities, a stretch with no idling, drain, random capacity
  phase_t phases [12] = '{
    '{7'd64,  1'b0, 85, 120, 1'b0, 1'b1},
    '{7'd127, 1'b0, 45, 100, 1'b0, 1'b0},
    '{7'd20,  1'b0, 50, 100, 1'b0, 1'b0},
    '{7'd0,   1'b0, 40,  60, 1'b0, 1'b0},
    '{7'd1,   1'b0, 50,  80, 1'b0, 1'b0},
    '{7'd3,   1'b0, 55, 100, 1'b1, 1'b0},
    '{7'd100, 1'b0, 85, 120, 1'b0, 1'b1},
    '{7'd65,  1'b0, 30, 120, 1'b0, 1'b0},
    '{7'd8,   1'b0, 60, 100, 1'b0, 1'b0},
    '{7'd64,  1'b0, 50, 150, 1'b0, 1'b0},
    '{7'd0,   1'b1, 55, 150, 1'b0, 1'b0},
    '{7'd33,  1'b0, 70, 150, 1'b0, 1'b0}
  };

  // Clock, reset and stimulus signals, all known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;
  logic [2:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  // Shadow stack kept by the predictor
  logic [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned       shadow_count;
  int unsigned       shadow_cap;

  // Results still owed by the block, oldest first
  isb_res_t          pending_results [$];

  // Run bookkeeping
  int unsigned       mismatches;
  int unsigned       items_sent;
  int unsigned       results_seen;
  int unsigned       cap_writes;
  int unsigned       refused_pushes;
  int unsigned       search_hits;
  int unsigned       cycle_count;

  // Pacing controls shared with the result receiver
  logic              idle_off      = 1'b0;
  int unsigned       hold_requests = 0;
  int unsigned       hold_taken    = 0;
  int unsigned       hold_left     = 0;

  integer_stack_with_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow stack and return the result it owes
  function automatic isb_res_t stack_apply(input logic [CMD_W-1:0] cmd,
                                           input logic [WORD_W-1:0] val);
    isb_res_t    res;
    int unsigned eff_cap;
    int unsigned i;
    logic        hit;
    res     = '0;
    res.status = 1'b1;
    eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    hit     = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count < eff_cap) begin
          shadow_words[shadow_count] = val;
          shadow_count++;
          res.status = 1'b0;
        end
      end
      CMD_POP: begin
        if (shadow_count > 0) begin
          shadow_count--;
          res.data   = shadow_words[shadow_count];
          res.status = 1'b0;
        end
      end
      CMD_PEEK: begin
        if (shadow_count > 0) begin
          res.data   = shadow_words[shadow_count - 1];
          res.status = 1'b0;
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        res.status   = 1'b0;
      end
      CMD_SEARCH: begin
        // topmost match wins, so scan downwards from the top
        for (i = shadow_count; i > 0; i--) begin
          if (!hit && shadow_words[i - 1] == val) begin
            hit        = 1'b1;
            res.pos    = POS_W'(i - 1);
            res.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(shadow_count);
    res.full  = (shadow_count >= eff_cap);
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb_top: mismatch on %s at cycle %0d: got %h, want %h",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  // Offer one item, hold it until taken, then log what it should produce
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                           input logic typed, input isb_res_t typed_res);
    isb_res_t predicted;
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = stack_apply(cmd, val);
    if (cmd == CMD_PUSH && predicted.status) refused_pushes++;
    if (cmd == CMD_SEARCH && !predicted.status) search_hits++;
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Stop offering and wait for every owed result, plus the search latency
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_cap  = cap;
    cap_writes++;
  endtask

  // Result receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_requests != hold_taken) begin
      hold_taken    <= hold_requests;
      hold_left     <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_off) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: compare every taken result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    isb_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[0] !== want.status)
          report_mismatch("status", 32'(m_axis_tuser[0]), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.data)
          report_mismatch("data", m_axis_tdata[31:0], want.data);
        if (m_axis_tdata[37:32] !== want.pos)
          report_mismatch("found_position", 32'(m_axis_tdata[37:32]), 32'(want.pos));
        if (m_axis_tdata[44:38] !== want.count)
          report_mismatch("count", 32'(m_axis_tdata[44:38]), 32'(want.count));
        if (m_axis_tdata[45] !== want.full)
          report_mismatch("is_full", 32'(m_axis_tdata[45]), 32'(want.full));
        if (m_axis_tdata[46] !== want.empty)
          report_mismatch("is_empty", 32'(m_axis_tdata[46]), 32'(want.empty));
        if (m_axis_tdata[47] !== 1'b0)
          report_mismatch("pad bit", 32'(m_axis_tdata[47]), 32'd0);
      end
    end
  end

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] val;
    logic [CAP_W-1:0]  cap;
    int unsigned       pick;

    mismatches     = 0;
    items_sent     = 0;
    results_seen   = 0;
    cap_writes     = 0;
    refused_pushes = 0;
    search_hits    = 0;
    cycle_count    = 0;
    shadow_count   = 0;
    shadow_cap     = CAP_RST;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Hold reset, then release it on an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-stack failures, extremes, every command,
    // undefined codes, zero capacity, capacity lowered below the fill level
    // and capacity above the build depth
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain_results();
        write_capacity(directed_rows[r].cap);
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].val,
                  directed_rows[r].typed, directed_rows[r].res);
      end
    end

    // Random part: each phase fixes a capacity and a push bias; the stack is
    // not cleared between phases, so capacities often land below the fill level
    foreach (phases[p]) begin
      drain_results();
      cap = phases[p].rand_cap ? CAP_W'($urandom_range(127)) : phases[p].cap;
      write_capacity(cap);
      idle_off <= phases[p].no_idle;
      // stall the receiver for a long stretch while items keep coming
      if (phases[p].rx_hold) hold_requests <= hold_requests + 1;
      for (int n = 0; n < phases[p].items; n++) begin
        pick = $urandom_range(99);
        if (pick < phases[p].push_pct) begin
          cmd = CMD_PUSH;
        end else begin
          pick = $urandom_range(99);
          if (pick < 40)      cmd = CMD_POP;
          else if (pick < 58) cmd = CMD_PEEK;
          else if (pick < 93) cmd = CMD_SEARCH;
          else if (pick < 97) cmd = CMD_CLEAR;
          else                cmd = CMD_W'($urandom_range(CMD_UNDEF5, CMD_UNDEF7));
        end
        // searches mostly look for a word that is held; other values are mostly
        // random, with part from a small pool so that duplicates and repeat hits occur
        pick = $urandom_range(99);
        if (cmd == CMD_SEARCH && shadow_count > 0 && pick < 60)
          val = shadow_words[$urandom_range(shadow_count - 1)];
        else if (pick < 75)
          val = $urandom();
        else if (pick < 88)
          val = WORD_W'($urandom_range(15));
        else
          val = WORD_EXTREMES[$urandom_range(3)];
        send_item(cmd, val, 1'b0, '0);
      end
      idle_off <= 1'b0;
    end

    drain_results();

    $display("tb_top: %0d items over %0d capacity settings, %0d results checked",
             items_sent, cap_writes, results_seen);
    $display("tb_top: %0d pushes refused, %0d searches matched",
             refused_pushes, search_hits);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
